// File: rtl/kth_order_statistic_select_assert.svh
// Assertion macros used by the top level of the kth order statistic select RTL.
`ifndef KTH_ORDER_STATISTIC_SELECT_ASSERT_SVH
`define KTH_ORDER_STATISTIC_SELECT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KOS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KOS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/kos_pkg.sv
// Package with types and constants of the kth order statistic select block.
package kos_pkg;

  localparam int DefMaxRank = 16;
  localparam int SampleW    = 32;
  localparam int SelW       = 5;
  localparam int CfgIdxW    = 1;

  localparam logic [CfgIdxW-1:0] CfgSelectCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgLargestMode = 1'b1;

  // Operation broadcast to every cell in a cycle.
  typedef struct packed {
    logic ins_en;  // insert the sample into the low part of the row
    logic rot_en;  // drop the lowest entry and insert the sample
  } cell_ctrl_t;

  // Position of a cell relative to the fill count.
  typedef struct packed {
    logic first;         // cell zero
    logic below_ins;     // index below the insert bound
    logic at_ins;        // index equal to the insert bound
    logic below_n;       // index below the fill count
    logic next_below_n;  // index plus one below the fill count
  } cell_pos_t;

  typedef struct packed {
    logic                      full;
    logic signed [SampleW-1:0] value;
  } out_item_t;

endpackage

// File: rtl/kos_cell.sv
// One cell of the sorted row: holds one kept sample and moves it to a neighbor.
module kos_cell (
  input  logic                              clk_i,
  input  logic signed [kos_pkg::SampleW-1:0] sample_i,
  input  kos_pkg::cell_ctrl_t               ctrl_i,
  input  kos_pkg::cell_pos_t                pos_i,
  input  logic signed [kos_pkg::SampleW-1:0] prev_val_i,
  input  logic                              prev_gt_i,
  input  logic signed [kos_pkg::SampleW-1:0] next_val_i,
  input  logic                              next_gt_i,
  output logic signed [kos_pkg::SampleW-1:0] val_o,
  output logic signed [kos_pkg::SampleW-1:0] nxt_o,
  output logic                              gt_o
);

  logic signed [kos_pkg::SampleW-1:0] val_q, val_d;
  logic gt;
  logic prev_g;

  always_comb begin
    gt     = val_q > sample_i;
    // Use the lower neighbor's compare only when this cell is at or below the insert bound.
    prev_g = prev_gt_i && (pos_i.below_ins || pos_i.at_ins);
    val_d  = val_q;
    if (ctrl_i.ins_en && (pos_i.below_ins || pos_i.at_ins)) begin
      if (prev_g) begin
        val_d = prev_val_i;
      end else if ((pos_i.below_ins && gt) || pos_i.at_ins) begin
        val_d = sample_i;
      end
    end else if (ctrl_i.rot_en && pos_i.below_n) begin
      if (pos_i.next_below_n && !next_gt_i) begin
        val_d = next_val_i;
      end else if (pos_i.first || !gt) begin
        val_d = sample_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign nxt_o = val_d;
  assign gt_o  = gt;

endmodule

// File: rtl/kos_out_buf.sv
// Two-entry output register that keeps the input side running while a result waits.
module kos_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  kos_pkg::out_item_t item_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               ready_i,
  output kos_pkg::out_item_t item_o
);

  logic               out_valid_q, out_valid_d;
  logic               skid_valid_q, skid_valid_d;
  kos_pkg::out_item_t out_q, out_d;
  kos_pkg::out_item_t skid_q, skid_d;
  logic               out_fire;

  always_comb begin
    out_fire     = out_valid_q && ready_i;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !ready_i) begin
        skid_d       = item_i;
        skid_valid_d = 1'b1;
      end else begin
        out_d       = item_i;
        out_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign item_o  = out_q;

endmodule

// File: rtl/kth_order_statistic_select.sv
// Top level of the streaming kth smallest or kth largest selection block.
// Throughput: one sample per cycle while the input is ready; cells compare and shift in parallel.
// Output: a set's result is registered as its last sample is taken, in the skid entry on a stall.
// A two-entry output register lets samples keep flowing while one result waits.
// Reset (asynchronous, active low) clears the fill count, the output valids and sets
// rank one in smallest mode; the kept samples themselves are not reset.
`include "kth_order_statistic_select_assert.svh"
module kth_order_statistic_select #(
  parameter int MAX_RANK = kos_pkg::DefMaxRank
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic signed [kos_pkg::SampleW-1:0] s_axis_tdata,  // [31:0] sample_value
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic signed [kos_pkg::SampleW-1:0] m_axis_tdata,  // [31:0] kth_value
  output logic                              m_axis_tuser,  // [0] set_was_full
  input  logic                              cfg_we_i,
  input  logic [kos_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [kos_pkg::SelW-1:0]          cfg_data_i
);

  localparam int CW = $clog2(MAX_RANK + 1);
  localparam int IW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

  logic [kos_pkg::SelW-1:0] select_count_q;
  logic                     largest_q;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            k_eff, nm1, m, n_new;
  logic                     in_fire, fill, smallest_hit, largest_hit;
  kos_pkg::cell_ctrl_t      ctrl;
  kos_pkg::out_item_t       result;

  logic signed [kos_pkg::SampleW-1:0] val_w [MAX_RANK];
  logic signed [kos_pkg::SampleW-1:0] nxt_w [MAX_RANK];
  logic                               gt_w  [MAX_RANK];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      select_count_q <= kos_pkg::SelW'(1);
      largest_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kos_pkg::CfgSelectCount: select_count_q <= cfg_data_i;
        kos_pkg::CfgLargestMode: largest_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (select_count_q == '0) begin
      k_eff = CW'(1);
    end else if (32'(select_count_q) > MAX_RANK) begin
      k_eff = CW'(MAX_RANK);
    end else begin
      k_eff = CW'(select_count_q);
    end
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign fill    = count_q < k_eff;
  assign nm1     = count_q - 1'b1;
  // Filling inserts up to index count_q; on replacement the bound is nm1 and the worst is dropped.
  assign m       = fill ? count_q : nm1;
  assign n_new   = fill ? count_q + 1'b1 : count_q;

  assign smallest_hit = gt_w[nm1[IW-1:0]];
  assign largest_hit  = val_w[0] < s_axis_tdata;

  always_comb begin
    ctrl.ins_en = in_fire && (fill || (!largest_q && smallest_hit));
    ctrl.rot_en = in_fire && !fill && largest_q && largest_hit;
  end

  for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
    kos_pkg::cell_pos_t                 pos;
    logic signed [kos_pkg::SampleW-1:0] prev_val, next_val;
    logic                               prev_gt, next_gt;

    always_comb begin
      pos.first        = (i == 0);
      pos.below_ins    = CW'(i) < m;
      pos.at_ins       = CW'(i) == m;
      pos.below_n      = CW'(i) < count_q;
      pos.next_below_n = CW'(i + 1) < count_q;
    end

    if (i == 0) begin : g_head
      assign prev_val = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_val = val_w[i-1];
      assign prev_gt  = gt_w[i-1];
    end

    if (i == MAX_RANK - 1) begin : g_tail
      assign next_val = val_w[i];
      assign next_gt  = 1'b0;
    end else begin : g_link
      assign next_val = val_w[i+1];
      assign next_gt  = gt_w[i+1];
    end

    kos_cell u_cell (
      .clk_i      (clk_i),
      .sample_i   (s_axis_tdata),
      .ctrl_i     (ctrl),
      .pos_i      (pos),
      .prev_val_i (prev_val),
      .prev_gt_i  (prev_gt),
      .next_val_i (next_val),
      .next_gt_i  (next_gt),
      .val_o      (val_w[i]),
      .nxt_o      (nxt_w[i]),
      .gt_o       (gt_w[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (in_fire) begin
      if (s_axis_tlast) begin
        count_d = '0;
      end else if (fill) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // The worst kept entry after this update sits at index m in smallest mode.
  always_comb begin
    result.full  = n_new >= k_eff;
    if (!result.full) begin
      result.value = '0;
    end else if (largest_q) begin
      result.value = nxt_w[0];
    end else begin
      result.value = nxt_w[m[IW-1:0]];
    end
  end

  kos_pkg::out_item_t out_item;

  kos_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_fire && s_axis_tlast),
    .item_i  (result),
    .ready_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .item_o  (out_item)
  );

  assign m_axis_tdata = out_item.value;
  assign m_axis_tuser = out_item.full;

  `KOS_ASSERT_SAME(a_count_bound, 1'b1, 32'(count_q) <= MAX_RANK, "fill count above rank limit")
  `KOS_ASSERT_NEXT(a_count_clear, in_fire && s_axis_tlast, count_q == '0,
                   "fill count not cleared after last sample")
  `KOS_ASSERT_NEXT(a_count_grow, in_fire && !s_axis_tlast && fill,
                   count_q == $past(count_q) + 1'b1, "fill count did not grow on insert")

endmodule

// File: tb/kth_order_statistic_select_test.sv
// Self-checking stream testbench for the kth order statistic select block.
module kth_order_statistic_select_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [kos_pkg::SampleW-1:0] sample_t;

  localparam sample_t SampleMin = {1'b1, {(kos_pkg::SampleW-1){1'b0}}};
  localparam sample_t SampleMax = {1'b0, {(kos_pkg::SampleW-1){1'b1}}};

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  sample_t                     s_axis_tdata;   // [31:0] sample_value
  logic                        s_axis_tlast;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  sample_t                     m_axis_tdata;   // [31:0] kth_value
  logic                        m_axis_tuser;   // [0] set_was_full
  logic                        cfg_we_i;
  logic [kos_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [kos_pkg::SelW-1:0]    cfg_data_i;

  kth_order_statistic_select dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow of the block: the kept samples in ascending order and the register values.
  sample_t                  top_k_store [kos_pkg::DefMaxRank];
  int unsigned              top_k_fill;
  logic [kos_pkg::SelW-1:0] rank_setting;
  logic                     largest_setting;
  kos_pkg::out_item_t       expected_kth_q [$];

  int unsigned mismatch_count;
  int unsigned samples_sent;
  int unsigned sets_sent;
  int unsigned results_checked;
  int unsigned rx_hold_cycles;
  bit          tx_idling;
  bit          rx_idling;

  function automatic void place_sorted(input sample_t v, input int unsigned n);
    int unsigned pos;
    pos = n;
    while (pos > 0 && top_k_store[pos-1] > v) begin
      top_k_store[pos] = top_k_store[pos-1];
      pos--;
    end
    top_k_store[pos] = v;
  endfunction

  function automatic void track_top_k(input sample_t v, input logic last);
    int unsigned        k;
    kos_pkg::out_item_t res;
    k = (rank_setting == 0) ? 1 :
        (rank_setting > kos_pkg::DefMaxRank) ? kos_pkg::DefMaxRank : rank_setting;
    if (top_k_fill < k) begin
      place_sorted(v, top_k_fill);
      top_k_fill++;
    end else if (largest_setting) begin
      // The least kept entry is the worst one; drop it and insert the sample in order.
      if (v > top_k_store[0]) begin
        for (int unsigned i = 0; i + 1 < top_k_fill; i++) top_k_store[i] = top_k_store[i+1];
        place_sorted(v, top_k_fill - 1);
      end
    end else if (v < top_k_store[top_k_fill-1]) begin
      place_sorted(v, top_k_fill - 1);
    end
    if (last) begin
      res.full  = (top_k_fill >= k);
      res.value = !res.full ? '0 :
                  largest_setting ? top_k_store[0] : top_k_store[top_k_fill-1];
      expected_kth_q.push_back(res);
      top_k_fill = 0;
    end
  endfunction

  function automatic sample_t draw_sample();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? SampleMin : SampleMax;
      1, 2:    return $urandom_range(0, 16) - 8;  // narrow range makes ties common
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_sample(input sample_t v, input logic last);
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = v;
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    samples_sent++;
    if (last) sets_sent++;
    track_top_k(v, last);
    @(negedge clk_i);
  endtask

  task automatic send_set(input int unsigned len);
    for (int unsigned n = 1; n <= len; n++) send_sample(draw_sample(), n == len);
  endtask

  // Stops offering samples and waits until every expected result has been checked.
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (expected_kth_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [kos_pkg::CfgIdxW-1:0] idx,
                           input logic [kos_pkg::SelW-1:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    if (idx == kos_pkg::CfgSelectCount) rank_setting = val;
    else largest_setting = val[0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic test_directed_cases();
    // Rank one in smallest mode straight out of reset.
    send_sample(SampleMin, 1'b1);
    send_sample(SampleMax, 1'b1);
    send_sample('0, 1'b0);
    send_sample(-1, 1'b1);
    settle();
    write_reg(kos_pkg::CfgSelectCount, 3);
    send_sample(SampleMax, 1'b0);
    send_sample(SampleMin, 1'b0);
    send_sample(5, 1'b0);
    send_sample(32'h5555_5555, 1'b0);
    send_sample(-1, 1'b1);
    settle();
    write_reg(kos_pkg::CfgSelectCount, 2);
    send_sample(4, 1'b0);
    send_sample(4, 1'b0);
    send_sample(4, 1'b1);
    // Fewer samples than the rank.
    settle();
    write_reg(kos_pkg::CfgSelectCount, 4);
    send_sample(1, 1'b0);
    send_sample(2, 1'b1);
    settle();
    write_reg(kos_pkg::CfgLargestMode, 1);
    write_reg(kos_pkg::CfgSelectCount, 3);
    send_sample(SampleMin, 1'b0);
    send_sample(10, 1'b0);
    send_sample(SampleMax, 1'b0);
    send_sample(10, 1'b0);
    send_sample(9, 1'b1);
    // A rank of zero behaves as rank one.
    settle();
    write_reg(kos_pkg::CfgSelectCount, 0);
    send_sample(3, 1'b0);
    send_sample(-3, 1'b1);
  endtask

  task automatic test_rank_limits();
    settle();
    write_reg(kos_pkg::CfgLargestMode, 0);
    write_reg(kos_pkg::CfgSelectCount, 17);
    send_set(20);
    settle();
    write_reg(kos_pkg::CfgSelectCount, 31);
    send_set(10);
    send_set(16);
    settle();
    write_reg(kos_pkg::CfgLargestMode, 1);
    write_reg(kos_pkg::CfgSelectCount, 16);
    send_set(16);
    send_set(15);
  endtask

  // Writes a register in the middle of an open set, while no sample is being offered.
  task automatic test_midset_reconfig();
    repeat (12) begin
      repeat ($urandom_range(1, 10)) send_sample(draw_sample(), 1'b0);
      settle();
      if ($urandom_range(0, 1))
        write_reg(kos_pkg::CfgSelectCount, kos_pkg::SelW'($urandom_range(1, 16)));
      else write_reg(kos_pkg::CfgLargestMode, !largest_setting);
      repeat ($urandom_range(0, 10)) send_sample(draw_sample(), 1'b0);
      send_sample(draw_sample(), 1'b1);
    end
  endtask

  task automatic test_output_backpressure();
    settle();
    write_reg(kos_pkg::CfgSelectCount, 1);
    tx_idling      = 1'b0;
    rx_hold_cycles = 300;
    repeat (30) send_set($urandom_range(1, 2));
    settle();
    tx_idling = 1'b1;
  endtask

  task automatic test_random_sets();
    int unsigned start;
    start = samples_sent;
    while (samples_sent - start < 340) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        if ($urandom_range(0, 7) == 0)
          write_reg(kos_pkg::CfgSelectCount, kos_pkg::SelW'($urandom_range(0, 31)));
        else write_reg(kos_pkg::CfgSelectCount, kos_pkg::SelW'($urandom_range(1, 16)));
        write_reg(kos_pkg::CfgLargestMode, kos_pkg::SelW'($urandom_range(0, 1)));
      end
      send_set($urandom_range(1, 24));
    end
  endtask

  task automatic test_steady_stream();
    settle();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    write_reg(kos_pkg::CfgSelectCount, 16);
    write_reg(kos_pkg::CfgLargestMode, 0);
    repeat (6) send_set($urandom_range(8, 24));
    settle();
    write_reg(kos_pkg::CfgSelectCount, 1);
    write_reg(kos_pkg::CfgLargestMode, 1);
    repeat (8) send_set($urandom_range(1, 4));
  endtask

  initial begin : rx_driver
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        m_axis_tready = 1'b0;
        repeat (rx_hold_cycles) @(negedge clk_i);
        rx_hold_cycles = 0;
      end else if (rx_idling && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    kos_pkg::out_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_kth_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d full %0b",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        want = expected_kth_q.pop_front();
        results_checked++;
        if (m_axis_tuser !== want.full)
          report_mismatch($sformatf("set_was_full %b, expected %b", m_axis_tuser, want.full));
        else if (m_axis_tdata !== want.value)
          report_mismatch($sformatf("kth_value %0d, expected %0d", m_axis_tdata, want.value));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", expected_kth_q.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tlast    = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = kos_pkg::CfgSelectCount;
    cfg_data_i      = '0;
    rank_setting    = 1;
    largest_setting = 1'b0;
    top_k_fill      = 0;
    mismatch_count  = 0;
    samples_sent    = 0;
    sets_sent       = 0;
    results_checked = 0;
    rx_hold_cycles  = 0;
    tx_idling       = 1'b1;
    rx_idling       = 1'b1;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_rank_limits();
    test_midset_reconfig();
    test_output_backpressure();
    test_random_sets();
    test_steady_stream();
    settle();

    $display("sent %0d samples in %0d sets and checked %0d results", samples_sent, sets_sent,
             results_checked);
    $display("ranks 0 to 31, both selection modes, mid-set changes, short sets, output stalls");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/kos_pkg.sv
rtl/kos_cell.sv
rtl/kos_out_buf.sv
rtl/kth_order_statistic_select.sv
tb/kth_order_statistic_select_test.sv
